FILE: hw/rtl/smwa_pkg.sv
`timescale 1ns / 1ps
// shared constants for the spectrum max-hold and window-average block
// no dependencies; imported by every module of the block
package smwa_pkg;

    // default sizing
    localparam int MAX_BINS_DEF     = 1024;
    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int SAMPLE_BITS_DEF  = 24;

    // configuration port
    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 1;
    localparam int FRAME_BINS_W   = 11;
    localparam int AVG_WINDOW_W   = 7;
    localparam int FRAME_BINS_RST = 1024;
    localparam int AVG_WINDOW_RST = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BINS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_WINDOW = 1'd1;

    // clamp a raw register value into lo..hi
    function automatic int f_clamp(input int val, input int lo, input int hi);
        int res;
        res = val;
        if (val < lo) begin
            res = lo;
        end else if (val > hi) begin
            res = hi;
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/smwa_acc.sv
`timescale 1ns / 1ps
// bin sequencing, peak/sum/count/history stores and their update stage
// depends on smwa_pkg for default sizing
module smwa_acc
    import smwa_pkg::*;
#(
    parameter int MAX_BINS     = MAX_BINS_DEF,
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    localparam int BIN_W  = $clog2(MAX_BINS),
    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
    localparam int FH_W   = $clog2(WINDOW_DEPTH + 1),
    localparam int SUM_W  = SAMPLE_BITS + FH_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_take,
    input  logic                          i_clear,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_sv,
    input  logic                          i_func,
    input  logic [BIN_W-1:0]              i_last_bin,
    input  logic [FH_W-1:0]               i_win,
    output logic                          o_busy,
    output logic                          o_valid,
    output logic [BIN_W-1:0]              o_bin,
    output logic signed [SAMPLE_BITS-1:0] o_peak,
    output logic                          o_pvalid,
    output logic signed [SUM_W-1:0]       o_sum,
    output logic [FH_W-1:0]               o_cnt,
    output logic                          o_last
);

    localparam int HADDR_W = SLOT_W + BIN_W;
    localparam int HDEPTH  = 2 ** HADDR_W;
    localparam int PK_W    = SAMPLE_BITS + 1;

    logic [PK_W-1:0]        mem_pk  [MAX_BINS];
    logic [SUM_W-1:0]       mem_sum [MAX_BINS];
    logic [FH_W-1:0]        mem_cnt [MAX_BINS];
    logic [PK_W-1:0]        mem_h   [HDEPTH];

    // sequencer state
    logic [BIN_W-1:0]       r_bin;
    logic                   r_mode;
    logic [FH_W-1:0]        r_held;
    logic [SLOT_W-1:0]      r_old;
    logic                   r_busy;
    logic [BIN_W-1:0]       r_cidx;

    logic                   cur_mode;
    logic                   last;
    logic                   full;
    logic [FH_W:0]          slot_sum;
    logic [FH_W:0]          slot_wrap;
    logic [SLOT_W-1:0]      slot;
    logic [SLOT_W-1:0]      nxt_old;
    logic [HADDR_W-1:0]     haddr;

    // stage a
    logic                   r_a_valid;
    logic [BIN_W-1:0]       r_a_bin;
    logic                   r_a_mode;
    logic                   r_a_full;
    logic signed [SAMPLE_BITS-1:0] r_a_s;
    logic                   r_a_sv;
    logic                   r_a_last;
    logic [HADDR_W-1:0]     r_a_haddr;
    logic                   r_a_fwd;
    logic                   r_a_hfwd;
    logic [PK_W-1:0]        r_pk_rd;
    logic [SUM_W-1:0]       r_sum_rd;
    logic [FH_W-1:0]        r_cnt_rd;
    logic [PK_W-1:0]        r_h_rd;

    // stage b
    logic                   r_b_valid;
    logic [BIN_W-1:0]       r_b_bin;
    logic signed [SAMPLE_BITS-1:0] r_b_peak;
    logic                   r_b_pvalid;
    logic signed [SUM_W-1:0] r_b_sum;
    logic [FH_W-1:0]        r_b_cnt;
    logic [PK_W-1:0]        r_b_h;
    logic                   r_b_last;

    logic signed [SAMPLE_BITS-1:0] pk_val;
    logic                   pk_valid;
    logic signed [SUM_W-1:0] sum_c;
    logic [FH_W-1:0]        cnt_c;
    logic [PK_W-1:0]        h_c;
    logic                   sub;
    logic signed [SUM_W-1:0] s_ext;
    logic signed [SUM_W-1:0] h_ext;
    logic signed [SAMPLE_BITS-1:0] n_peak;
    logic                   n_pvalid;
    logic signed [SUM_W-1:0] n_sum;
    logic [FH_W-1:0]        n_cnt;

    always_comb begin
        cur_mode  = (r_bin == '0) ? i_func : r_mode;
        last      = (r_bin == i_last_bin);
        full      = (r_held == i_win);
        slot_sum  = (FH_W+1)'(r_old) + (FH_W+1)'(r_held);
        slot_wrap = (slot_sum >= (FH_W+1)'(i_win)) ? slot_sum - (FH_W+1)'(i_win) : slot_sum;
        slot      = full ? r_old : SLOT_W'(slot_wrap);
        nxt_old   = ((FH_W+1)'(r_old) + 1'b1 == (FH_W+1)'(i_win)) ? '0 : r_old + 1'b1;
        haddr     = {slot, r_bin};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_bin  <= '0;
            r_mode <= 1'b0;
            r_held <= '0;
            r_old  <= '0;
            r_busy <= 1'b1;
            r_cidx <= '0;
        end else begin
            if (r_busy) begin
                r_cidx <= r_cidx + 1'b1;
                if (r_cidx == BIN_W'(MAX_BINS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
            if (i_take) begin
                r_bin  <= last ? '0 : r_bin + 1'b1;
                r_mode <= cur_mode;
                if (cur_mode && last) begin
                    if (!full) begin
                        r_held <= r_held + 1'b1;
                    end else begin
                        r_old <= nxt_old;
                    end
                end
            end
        end
    end

    // memory reads issue with the request; stage a sees registered data
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_pk_rd   <= mem_pk[r_bin];
            r_sum_rd  <= mem_sum[r_bin];
            r_cnt_rd  <= mem_cnt[r_bin];
            r_h_rd    <= mem_h[haddr];
            r_a_bin   <= r_bin;
            r_a_mode  <= cur_mode;
            r_a_full  <= full;
            r_a_s     <= i_sample;
            r_a_sv    <= i_sv;
            r_a_last  <= last;
            r_a_haddr <= haddr;
            r_a_fwd   <= r_a_valid && (r_a_bin == r_bin);
            r_a_hfwd  <= r_a_valid && r_a_mode && (r_a_haddr == haddr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_take;
            r_b_valid <= r_a_valid;
        end
    end

    // read-modify-write with forwarding from the item just ahead
    always_comb begin
        pk_val   = r_a_fwd ? r_b_peak   : r_pk_rd[SAMPLE_BITS-1:0];
        pk_valid = r_a_fwd ? r_b_pvalid : r_pk_rd[SAMPLE_BITS];
        sum_c    = r_a_fwd ? r_b_sum    : r_sum_rd;
        cnt_c    = r_a_fwd ? r_b_cnt    : r_cnt_rd;
        h_c      = r_a_hfwd ? r_b_h     : r_h_rd;
        s_ext    = SUM_W'(r_a_s);
        h_ext    = SUM_W'(signed'(h_c[SAMPLE_BITS-1:0]));
        sub      = r_a_full && h_c[SAMPLE_BITS];
        n_peak   = pk_val;
        n_pvalid = pk_valid;
        n_sum    = sum_c;
        n_cnt    = cnt_c;
        if (!r_a_mode) begin
            if (r_a_sv && (!pk_valid || r_a_s > pk_val)) begin
                n_peak   = r_a_s;
                n_pvalid = 1'b1;
            end
        end else begin
            n_sum = sum_c - (sub ? h_ext : '0) + (r_a_sv ? s_ext : '0);
            n_cnt = cnt_c - FH_W'(sub && (cnt_c != '0)) + FH_W'(r_a_sv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem_pk[r_cidx]  <= '0;
            mem_sum[r_cidx] <= '0;
            mem_cnt[r_cidx] <= '0;
        end else if (i_en && r_a_valid) begin
            mem_pk[r_a_bin]  <= {n_pvalid, n_peak};
            mem_sum[r_a_bin] <= n_sum;
            mem_cnt[r_a_bin] <= n_cnt;
        end
        if (i_en && r_a_valid && r_a_mode) begin
            mem_h[r_a_haddr] <= {r_a_sv, r_a_s};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && r_a_valid) begin
            r_b_bin    <= r_a_bin;
            r_b_peak   <= n_peak;
            r_b_pvalid <= n_pvalid;
            r_b_sum    <= n_sum;
            r_b_cnt    <= n_cnt;
            r_b_h      <= {r_a_sv, r_a_s};
            r_b_last   <= r_a_last;
        end
    end

    assign o_busy   = r_busy;
    assign o_valid  = r_b_valid;
    assign o_bin    = r_b_bin;
    assign o_peak   = r_b_pvalid ? r_b_peak : '0;
    assign o_pvalid = r_b_pvalid;
    assign o_sum    = r_b_sum;
    assign o_cnt    = r_b_cnt;
    assign o_last   = r_b_last;

endmodule

FILE: hw/rtl/smwa_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, side data carried along
// depends on smwa_pkg for default sizing
module smwa_div
    import smwa_pkg::*;
#(
    parameter int DW     = SAMPLE_BITS_DEF + 7,
    parameter int VW     = 7,
    parameter int OUT_W  = SAMPLE_BITS_DEF,
    parameter int SIDE_W = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [DW-1:0]    i_sum,
    input  logic [VW-1:0]           i_cnt,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_quot,
    output logic                    o_qvalid,
    output logic [SIDE_W-1:0]       o_side
);

    logic              r_v    [DW+1];
    logic [DW-1:0]     r_dq   [DW+1];
    logic [VW-1:0]     r_rem  [DW+1];
    logic [VW-1:0]     r_d    [DW+1];
    logic              r_neg  [DW+1];
    logic [SIDE_W-1:0] r_side [DW+1];

    logic              r_o_valid;
    logic [OUT_W-1:0]  r_o_quot;
    logic              r_o_qvalid;
    logic [SIDE_W-1:0] r_o_side;
    logic [DW-1:0]     q_signed;

    // stage zero: magnitude and sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en && i_valid) begin
            r_dq[0]   <= i_sum[DW-1] ? DW'(-i_sum) : DW'(i_sum);
            r_rem[0]  <= '0;
            r_d[0]    <= i_cnt;
            r_neg[0]  <= i_sum[DW-1];
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= DW; k++) begin : g_stage
        logic [VW:0] trial;
        logic        take;
        always_comb begin
            trial = {r_rem[k-1], r_dq[k-1][DW-1]};
            take  = (trial >= {1'b0, r_d[k-1]});
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
            if (i_en && r_v[k-1]) begin
                r_rem[k]  <= take ? VW'(trial - {1'b0, r_d[k-1]}) : VW'(trial);
                r_dq[k]   <= {r_dq[k-1][DW-2:0], take};
                r_d[k]    <= r_d[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign q_signed = r_neg[DW] ? -r_dq[DW] : r_dq[DW];

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_o_valid <= r_v[DW];
        end
        if (i_en && r_v[DW]) begin
            r_o_qvalid <= (r_d[DW] != '0);
            r_o_quot   <= (r_d[DW] != '0) ? q_signed[OUT_W-1:0] : '0;
            r_o_side   <= r_side[DW];
        end
    end

    assign o_valid  = r_o_valid;
    assign o_quot   = r_o_quot;
    assign o_qvalid = r_o_qvalid;
    assign o_side   = r_o_side;

endmodule

FILE: hw/rtl/spectrum_max_hold_and_window_average_top.sv
`timescale 1ns / 1ps
// top level of the spectrum max-hold and window-average block
// depends on smwa_pkg, smwa_acc and smwa_div
//
// spectrum bins enter on the input channel (i_in_valid / o_in_ready), one
// request per bin, carrying the sample, its validity flag and the trace mode;
// the mode seen on bin 0 holds for the whole frame. every request gives one
// result on the output channel (o_out_valid / i_out_ready): bin index, held
// peak, windowed mean and a frame-end flag.
// throughput: one request per cycle while the receiver keeps up and no clearing
// pass runs. the mean is formed by a bit-per-stage divider behind two store
// access stages (read, then update and write back).
// after reset, and after any configuration write, a clearing pass zeroes the
// peak, sum and count stores; o_in_ready stays low meanwhile (configuration
// writes are still taken). the history ring is never cleared: an entry is
// only read once written in the current window.
// when the receiver stalls the whole pipeline holds in place; nothing is
// dropped or repeated, and intake resumes as soon as the output is taken.
module spectrum_max_hold_and_window_average_top
    import smwa_pkg::*;
#(
    parameter int MAX_BINS     = MAX_BINS_DEF,
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    localparam int BIN_W = $clog2(MAX_BINS),
    localparam int FH_W  = $clog2(WINDOW_DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data,
    // input requests
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_sample_valid,
    input  logic                          i_func,
    // results
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [BIN_W-1:0]              o_bin_index,
    output logic signed [SAMPLE_BITS-1:0] o_peak_value,
    output logic                          o_peak_valid,
    output logic signed [SAMPLE_BITS-1:0] o_mean_value,
    output logic                          o_mean_valid,
    output logic                          o_frame_end
);

    localparam int SUM_W  = SAMPLE_BITS + FH_W;
    localparam int SIDE_W = BIN_W + SAMPLE_BITS + 2;

    // effective settings, clamped on write
    logic [BIN_W-1:0]  r_last_bin;
    logic [FH_W-1:0]   r_win;
    logic [BIN_W-1:0]  n_last_bin;
    logic [FH_W-1:0]   n_win;

    logic              en;
    logic              take;
    logic              busy;

    logic                          b_valid;
    logic [BIN_W-1:0]              b_bin;
    logic signed [SAMPLE_BITS-1:0] b_peak;
    logic                          b_pvalid;
    logic signed [SUM_W-1:0]       b_sum;
    logic [FH_W-1:0]               b_cnt;
    logic                          b_last;
    logic [SIDE_W-1:0]             side_in;
    logic [SIDE_W-1:0]             side_out;

    always_comb begin
        n_last_bin = BIN_W'(f_clamp(int'(i_cfg_data[FRAME_BINS_W-1:0]), 1, MAX_BINS) - 1);
        n_win      = FH_W'(f_clamp(int'(i_cfg_data[AVG_WINDOW_W-1:0]), 1, WINDOW_DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_bin <= BIN_W'(f_clamp(FRAME_BINS_RST, 1, MAX_BINS) - 1);
            r_win      <= FH_W'(f_clamp(AVG_WINDOW_RST, 1, WINDOW_DEPTH));
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_BINS: begin
                    r_last_bin <= n_last_bin;
                end
                CFG_AVG_WINDOW: begin
                    r_win <= n_win;
                end
                default: begin
                end
            endcase
        end
    end

    // the pipeline moves as a whole whenever the output register frees up
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en && !busy;
    assign take       = i_in_valid && o_in_ready;

    smwa_acc #(
        .MAX_BINS     (MAX_BINS),
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_take     (take),
        .i_clear    (i_cfg_we),
        .i_sample   (i_sample),
        .i_sv       (i_sample_valid),
        .i_func     (i_func),
        .i_last_bin (r_last_bin),
        .i_win      (r_win),
        .o_busy     (busy),
        .o_valid    (b_valid),
        .o_bin      (b_bin),
        .o_peak     (b_peak),
        .o_pvalid   (b_pvalid),
        .o_sum      (b_sum),
        .o_cnt      (b_cnt),
        .o_last     (b_last)
    );

    // peak, bin and frame end ride alongside the mean divider
    assign side_in = {b_bin, b_peak, b_pvalid, b_last};

    smwa_div #(
        .DW     (SUM_W),
        .VW     (FH_W),
        .OUT_W  (SAMPLE_BITS),
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (b_valid),
        .i_sum    (b_sum),
        .i_cnt    (b_cnt),
        .i_side   (side_in),
        .o_valid  (o_out_valid),
        .o_quot   (o_mean_value),
        .o_qvalid (o_mean_valid),
        .o_side   (side_out)
    );

    assign o_bin_index  = side_out[SIDE_W-1 -: BIN_W];
    assign o_peak_value = side_out[SAMPLE_BITS+1:2];
    assign o_peak_valid = side_out[1];
    assign o_frame_end  = side_out[0];

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for spectrum_max_hold_and_window_average_top
// depends on smwa_pkg and the block's rtl; a built-in predictor checks every result
//
// approach: an initial block queues spectrum requests phase by phase and rewrites
// the registers between phases, once the block has drained. a clocked driver
// offers requests in bursts with random gaps. a clocked monitor takes results
// under a stall pattern of its own and compares each field against the
// predicted result held in a queue. the predictor keeps its own peak, ring,
// sum and count stores.
module testbench;
    import smwa_pkg::*;

    localparam int NBINS  = 1024;
    localparam int NSLOTS = 64;
    localparam int SW     = 24;
    localparam bit MODE_PEAK = 1'b0;
    localparam bit MODE_AVG  = 1'b1;
    localparam int DRAIN_CYCLES = 45;   // block latency plus margin

    typedef struct {
        logic signed [SW-1:0] smp;
        logic                 ok;
        logic                 mode;
    } bin_req_t;

    typedef struct {
        logic [9:0]           bin;
        logic signed [SW-1:0] peak;
        logic                 peak_ok;
        logic signed [SW-1:0] mean;
        logic                 mean_ok;
        logic                 last;
    } bin_res_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic signed [SW-1:0] i_sample = '0;
    logic                 i_sample_valid = 1'b0;
    logic                 i_func = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [9:0]           o_bin_index;
    logic signed [SW-1:0] o_peak_value;
    logic                 o_peak_valid;
    logic signed [SW-1:0] o_mean_value;
    logic                 o_mean_valid;
    logic                 o_frame_end;

    spectrum_max_hold_and_window_average_top dut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // predictor state
    int unsigned          cfg_bins, cfg_win;
    int unsigned          bin_pos, frames_in, oldest;
    logic                 frame_mode;
    logic signed [SW-1:0] peak_val [NBINS];
    bit                   peak_ok  [NBINS];
    logic signed [SW-1:0] ring_val [NSLOTS*NBINS];
    bit                   ring_ok  [NSLOTS*NBINS];
    longint               bin_sum  [NBINS];
    int unsigned          bin_cnt  [NBINS];

    bin_req_t pending_bins[$];
    bin_res_t expected_bins[$];
    int       errors = 0;
    int       results_taken = 0;

    function automatic void clear_traces();
        bin_pos = 0; frames_in = 0; oldest = 0; frame_mode = MODE_PEAK;
        for (int i = 0; i < NBINS; i++) begin
            peak_ok[i] = 0; peak_val[i] = '0; bin_sum[i] = 0; bin_cnt[i] = 0;
        end
    endfunction

    function automatic void trace_step(bin_req_t r);
        int unsigned nb, w, b, slot, k;
        bin_res_t    e;
        nb = (cfg_bins < 1) ? 1 : (cfg_bins > NBINS) ? NBINS : cfg_bins;
        w  = (cfg_win < 1) ? 1 : (cfg_win > NSLOTS) ? NSLOTS : cfg_win;
        if (bin_pos >= nb) bin_pos = 0;
        if (bin_pos == 0) frame_mode = r.mode;
        b = bin_pos;
        e.last = (b + 1 == nb);
        if (frame_mode == MODE_PEAK) begin
            if (r.ok && (!peak_ok[b] || r.smp > peak_val[b])) begin
                peak_val[b] = r.smp;
                peak_ok[b]  = 1;
            end
        end else begin
            slot = (frames_in < w) ? (oldest + frames_in) % w : oldest % w;
            k = slot * NBINS + b;
            if (frames_in >= w && ring_ok[k]) begin
                bin_sum[b] -= ring_val[k];
                if (bin_cnt[b] > 0) bin_cnt[b]--;
            end
            ring_val[k] = r.smp;
            ring_ok[k]  = r.ok;
            if (r.ok) begin
                bin_sum[b] += r.smp;
                bin_cnt[b]++;
            end
            if (e.last) begin
                if (frames_in < w) frames_in++;
                else oldest = (oldest + 1) % w;
            end
        end
        e.bin     = b[9:0];
        e.peak    = peak_ok[b] ? peak_val[b] : '0;
        e.peak_ok = peak_ok[b];
        e.mean_ok = bin_cnt[b] > 0;
        e.mean    = e.mean_ok ? SW'(bin_sum[b] / longint'(bin_cnt[b])) : '0;
        expected_bins.insert(expected_bins.size(), e);
        bin_pos = e.last ? 0 : b + 1;
    endfunction

    // ---------------- driver: bursts of requests with random gaps ----------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        bin_req_t nxt;
        logic     nv;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            nv = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                trace_step('{i_sample, i_sample_valid, i_func});
                nv = 1'b0;
            end
            // a free slot: either leave a gap or offer the next bin
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_bins.size() > 0) begin
                    nxt = pending_bins[0];
                    pending_bins.delete(0);
                    i_sample       <= nxt.smp;
                    i_sample_valid <= nxt.ok;
                    i_func         <= nxt.mode;
                    nv = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 20);
                        // roughly half the bursts run back to back
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            i_in_valid <= nv;
        end
    end

    // ---------------- receiver stall pattern, with one long hold ----------------
    int  stall_style = 0;
    int  style_left  = 0;
    int  hold_left   = 0;
    bit  hold_done   = 0;
    int  rx_tick     = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            rx_tick++;
            if (!hold_done && results_taken >= 150) begin
                hold_done = 1;
                hold_left = 300;    // long enough for the pipeline to back up
            end
            if (style_left == 0) begin
                stall_style = $urandom_range(0, 2);
                style_left  = $urandom_range(20, 120);
            end else begin
                style_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (stall_style)
                    0: begin
                        i_out_ready <= 1'b1;
                    end
                    1: begin
                        i_out_ready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        i_out_ready <= (rx_tick % 3) != 0;
                    end
                endcase
            end
        end
    end

    // ---------------- monitor: compare against the oldest prediction ----------------
    always @(posedge i_clk) begin
        bin_res_t e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_taken++;
            if (expected_bins.size() == 0) begin
                $error("unexpected result for bin %0d", o_bin_index);
                errors++;
            end else begin
                e = expected_bins[0];
                expected_bins.delete(0);
                if (o_bin_index !== e.bin) begin
                    $error("bin_index exp %0d got %0d", e.bin, o_bin_index);
                    errors++;
                end
                if (o_peak_value !== e.peak) begin
                    $error("peak_value exp %0d got %0d", e.peak, o_peak_value);
                    errors++;
                end
                if (o_peak_valid !== e.peak_ok) begin
                    $error("peak_valid exp %0b got %0b", e.peak_ok, o_peak_valid);
                    errors++;
                end
                if (o_mean_value !== e.mean) begin
                    $error("mean_value exp %0d got %0d", e.mean, o_mean_value);
                    errors++;
                end
                if (o_mean_valid !== e.mean_ok) begin
                    $error("mean_valid exp %0b got %0b", e.mean_ok, o_mean_valid);
                    errors++;
                end
                if (o_frame_end !== e.last) begin
                    $error("frame_end exp %0b got %0b", e.last, o_frame_end);
                    errors++;
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic void queue_bin(logic signed [SW-1:0] s, logic ok, logic m);
        bin_req_t r;
        r.smp = s; r.ok = ok; r.mode = m;
        pending_bins.insert(pending_bins.size(), r);
    endfunction

    function automatic logic signed [SW-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'sh7fffff;
            1: return 24'sh800000;
            2: return SW'(int'($urandom_range(0, 20)) - 10);
            default: return SW'($urandom);
        endcase
    endfunction

    // hold the sender until every request is taken and every result has come
    task automatic drain();
        while (pending_bins.size() > 0 || i_in_valid || expected_bins.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(val);
        if (idx == CFG_FRAME_BINS) cfg_bins = val & 11'h7ff;
        else cfg_win = val & 7'h7f;
        clear_traces();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    int phase_bins [10] = '{3, 1, 2, 0, 2047, 5, 1024, 7, 2, 4};
    int phase_win  [10] = '{2, 1, 64, 0, 127, 3, 64, 1, 5, 64};
    int phase_len  [10] = '{30, 20, 150, 15, 20, 50, 20, 40, 60, 60};

    initial begin
        int avg_pct;
        cfg_bins = FRAME_BINS_RST;
        cfg_win  = AVG_WINDOW_RST;
        clear_traces();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: long frames, peak mode taken from bin 0
        queue_bin(24'sh7fffff, 1, MODE_PEAK);
        queue_bin(24'sh800000, 1, MODE_AVG);
        queue_bin(24'sd5, 0, MODE_AVG);
        queue_bin(-24'sd1, 1, MODE_PEAK);
        drain();

        // directed: 4 bins, window of 2
        write_reg(CFG_FRAME_BINS, 4);
        write_reg(CFG_AVG_WINDOW, 2);
        // first valid taken as is, invalid never held
        queue_bin(24'sh800000, 1, MODE_PEAK);
        queue_bin(24'sh7fffff, 1, MODE_PEAK);
        queue_bin(24'sd9, 0, MODE_PEAK);
        queue_bin(-24'sd3, 1, MODE_PEAK);
        // smaller and invalid do not replace, larger does; mode ignored mid-frame
        queue_bin(24'sh7fffff, 0, MODE_PEAK);
        queue_bin(24'sh000000, 1, MODE_AVG);
        queue_bin(24'sd9, 1, MODE_AVG);
        queue_bin(-24'sd4, 1, MODE_PEAK);
        // average frames: fill the window, then roll the oldest out
        queue_bin(-24'sd7, 1, MODE_AVG);
        queue_bin(24'sh7fffff, 1, MODE_PEAK);
        queue_bin(24'sd1, 0, MODE_PEAK);
        queue_bin(24'sh800000, 1, MODE_PEAK);
        queue_bin(24'sd2, 1, MODE_AVG);
        queue_bin(24'sh7fffff, 1, MODE_AVG);
        queue_bin(24'sd1, 1, MODE_AVG);
        queue_bin(24'sh800000, 0, MODE_AVG);
        queue_bin(24'sd4, 0, MODE_AVG);
        queue_bin(24'sd3, 1, MODE_AVG);
        queue_bin(24'sd5, 1, MODE_AVG);
        queue_bin(24'sh800000, 1, MODE_AVG);
        drain();

        // random phases, extremes and out-of-range register values among them
        for (int p = 0; p < 10; p++) begin
            if (p % 2 == 0) begin
                write_reg(CFG_AVG_WINDOW, phase_win[p]);
                write_reg(CFG_FRAME_BINS, phase_bins[p]);
            end else begin
                write_reg(CFG_FRAME_BINS, phase_bins[p]);
                write_reg(CFG_AVG_WINDOW, phase_win[p]);
            end
            // window-filling phases lean on average frames
            avg_pct = (phase_win[p] >= 5) ? 85 : 50;
            for (int n = 0; n < phase_len[p]; n++)
                queue_bin(rand_sample(), $urandom_range(0, 99) < 80,
                          $urandom_range(0, 99) < avg_pct);
            drain();
        end

        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #2ms;
        $display("testbench: errors");
        $finish;
    end

endmodule
